// ===== src/spf_pkg.sv =====
// Shared types and constants for the string period finder.
// No dependencies; every other file of the block but spf_ram refers to this package.
package spf_pkg;

  // Default word buffer depth, in symbols.
  localparam int unsigned MaxLenDef = 256;

  // Width of one symbol of the word.
  localparam int unsigned SymW = 8;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // What the back has to do with a symbol.
  typedef enum logic [1:0] {
    KIND_FIRST,   // first symbol of a word, border is zero by definition
    KIND_EXTEND,  // stored symbol that needs the border search
    KIND_DROP     // buffer full, symbol only marks the overflow
  } kind_e;

  // One queued transaction from the front to the back.
  typedef struct packed {
    kind_e             kind;
    logic [SymW-1:0]   symbol;
    logic              last;
  } q_entry_t;

  // Sequencer states of the back.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EMIT
  } back_state_e;

endpackage

// ===== src/string_period_finder_top.sv =====
// Top level of the string period finder: front, queue and back.
// Depends on spf_pkg, spf_front, spf_queue, spf_back and spf_ram.
//
// The block reads a word one byte per input transaction, with tlast on the
// final byte, and builds the KMP prefix function (longest proper border of
// every prefix) while the word streams in. After the final byte it sends
// one output transaction: the smallest period of the word (length minus the
// final border) in the low bits of tdata, the final border above it, and
// tuser set when the word was longer than MAX_LEN symbols; in that case the
// extra symbols are ignored and the result covers the first MAX_LEN only.
// The front takes one transaction per cycle, while the queue is not full,
// into a two-entry queue. The back handles the first symbol of a word and
// a dropped symbol in its idle state; any other symbol moves on to the match
// state, which repeats for every step it falls back through the border
// table; each step is one registered read of the symbol and border RAMs.
// Fallback steps over a whole word add up to at most its length. After the
// final symbol the emit state loads the result register once it is free.
// The result register lets the back keep working on the next word while a
// result waits to be taken. No clearing pass follows reset.
module string_period_finder_top #(
  parameter int unsigned MAX_LEN = spf_pkg::MaxLenDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input word stream.
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [spf_pkg::SymW-1:0]   s_axis_tdata_i,  // [7:0] symbol
  input  logic                       s_axis_tlast_i,  // last symbol of the word
  // Result stream.
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // From bit 0 up: period, border, zero padding to whole bytes.
  output logic [((($clog2(MAX_LEN + 1) + $clog2(MAX_LEN)) + 7) / 8) * 8 - 1:0]
                                     m_axis_tdata_o,
  output logic                       m_axis_tuser_o   // overflow
);

  localparam int unsigned CntW     = $clog2(MAX_LEN + 1);
  localparam int unsigned IdxW     = $clog2(MAX_LEN);

  logic              push;
  logic              full;
  logic              q_valid;
  logic              q_pop;
  spf_pkg::q_entry_t push_entry;
  spf_pkg::q_entry_t head_entry;

  logic [CntW-1:0]   period;
  logic [IdxW-1:0]   border;

  spf_front #(
    .MaxLen (MAX_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_symbol_i (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full)
  );

  spf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  spf_back #(
    .MaxLen (MAX_LEN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (head_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_period_o   (period),
    .out_border_o   (border),
    .out_overflow_o (m_axis_tuser_o)
  );

  // Pack period and border without gaps; the remaining bits stay zero.
  always_comb begin
    m_axis_tdata_o              = '0;
    m_axis_tdata_o[CntW-1:0]    = period;
    m_axis_tdata_o[CntW+:IdxW]  = border;
  end

endmodule

// ===== src/spf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spf_front.sv =====
// Front of the string period finder: accepts symbols and classifies them.
// Depends on spf_pkg.
module spf_front #(
  parameter int unsigned MaxLen = spf_pkg::MaxLenDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [spf_pkg::SymW-1:0] in_symbol_i,
  input  logic              in_last_i,
  output logic              push_o,
  output spf_pkg::q_entry_t entry_o,
  input  logic              full_i
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // The front keeps its own count of stored symbols so that it can tell
  // the back which symbols open a word and which fall past the buffer.
  always_comb begin
    entry_o.symbol = in_symbol_i;
    entry_o.last   = in_last_i;
    if (count_q >= CntW'(MaxLen)) begin
      entry_o.kind = spf_pkg::KIND_DROP;
    end else if (count_q == '0) begin
      entry_o.kind = spf_pkg::KIND_FIRST;
    end else begin
      entry_o.kind = spf_pkg::KIND_EXTEND;
    end
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (in_last_i) begin
        count_d = '0;
      end else if (entry_o.kind != spf_pkg::KIND_DROP) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== src/spf_queue.sv =====
// Short queue of classified symbols between the front and the back.
// Depends on spf_pkg.
module spf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spf_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output spf_pkg::q_entry_t entry_o
);

  localparam int unsigned PtrW = spf_pkg::QueuePtrW;
  localparam int unsigned CntW = spf_pkg::QueueCntW;

  spf_pkg::q_entry_t slot_q [spf_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == CntW'(spf_pkg::QueueDepth));
  assign valid_o = (fill_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(spf_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(spf_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// ===== src/spf_back.sv =====
// Back of the string period finder: border search sequencer, symbol and
// border RAMs, and the result register. Depends on spf_pkg and spf_ram.
module spf_back #(
  parameter int unsigned MaxLen = spf_pkg::MaxLenDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  spf_pkg::q_entry_t                 q_entry_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [$clog2(MaxLen + 1)-1:0]     out_period_o,
  output logic [$clog2(MaxLen)-1:0]         out_border_o,
  output logic                              out_overflow_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned IdxW = $clog2(MaxLen);
  localparam int unsigned SymW = spf_pkg::SymW;

  spf_pkg::back_state_e state_q, state_d;

  logic [SymW-1:0] sym_q, sym_d;
  logic            last_q, last_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] border_q, border_d;
  logic            ovf_q, ovf_d;

  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] out_period_q, out_period_d;
  logic [IdxW-1:0] out_border_q, out_border_d;
  logic            out_ovf_q, out_ovf_d;

  logic            sym_we, tbl_we;
  logic [IdxW-1:0] waddr;
  logic [IdxW-1:0] tbl_wdata;
  logic [SymW-1:0] sym_wdata;
  logic [IdxW-1:0] sym_raddr, tbl_raddr;
  logic [SymW-1:0] sym_rdata;
  logic [IdxW-1:0] tbl_rdata;

  logic            match;
  logic            resolve;
  logic            slot_free;

  assign match     = (sym_rdata == sym_q);
  assign resolve   = match || (border_q == '0);
  assign slot_free = !out_valid_q || out_ready_i;

  spf_ram #(
    .Width (SymW),
    .Depth (MaxLen)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (waddr),
    .wdata_i (sym_wdata),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  spf_ram #(
    .Width (IdxW),
    .Depth (MaxLen)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      spf_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.kind == spf_pkg::KIND_EXTEND) begin
            state_d = spf_pkg::ST_MATCH;
          end else if (q_entry_i.last) begin
            state_d = spf_pkg::ST_EMIT;
          end
        end
      end
      spf_pkg::ST_MATCH: begin
        if (resolve) begin
          state_d = last_q ? spf_pkg::ST_EMIT : spf_pkg::ST_IDLE;
        end
      end
      spf_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = spf_pkg::ST_IDLE;
        end
      end
      default: state_d = spf_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM control and outputs.
  always_comb begin
    q_pop_o      = 1'b0;
    sym_d        = sym_q;
    last_d       = last_q;
    count_d      = count_q;
    border_d     = border_q;
    ovf_d        = ovf_q;
    sym_we       = 1'b0;
    tbl_we       = 1'b0;
    waddr        = count_q[IdxW-1:0];
    sym_wdata    = sym_q;
    tbl_wdata    = '0;
    sym_raddr    = border_q;
    tbl_raddr    = border_q - IdxW'(1);
    out_period_d = out_period_q;
    out_border_d = out_border_q;
    out_ovf_d    = out_ovf_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    case (state_q)
      spf_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          sym_d   = q_entry_i.symbol;
          last_d  = q_entry_i.last;
          case (q_entry_i.kind)
            spf_pkg::KIND_DROP: begin
              ovf_d = 1'b1;
            end
            spf_pkg::KIND_FIRST: begin
              sym_we    = 1'b1;
              tbl_we    = 1'b1;
              sym_wdata = q_entry_i.symbol;
              tbl_wdata = '0;
              border_d  = '0;
              count_d   = count_q + CntW'(1);
            end
            default: begin
              // Border search starts at the running border; the reads
              // addressed by it land in the next cycle.
            end
          endcase
        end
      end
      spf_pkg::ST_MATCH: begin
        if (match) begin
          tbl_wdata = border_q + IdxW'(1);
        end else begin
          tbl_wdata = '0;
        end
        if (resolve) begin
          sym_we   = 1'b1;
          tbl_we   = 1'b1;
          border_d = tbl_wdata;
          count_d  = count_q + CntW'(1);
        end else begin
          // Fall back through the border table and fetch the next candidate.
          border_d  = tbl_rdata;
          sym_raddr = tbl_rdata;
          tbl_raddr = tbl_rdata - IdxW'(1);
        end
      end
      spf_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_period_d = count_q - CntW'(border_q);
          out_border_d = border_q;
          out_ovf_d    = ovf_q;
          count_d      = '0;
          border_d     = '0;
          ovf_d        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    last_q       <= last_d;
    out_period_q <= out_period_d;
    out_border_q <= out_border_d;
    out_ovf_q    <= out_ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spf_pkg::ST_IDLE;
      count_q     <= '0;
      border_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      border_q    <= border_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_period_o   = out_period_q;
  assign out_border_o   = out_border_q;
  assign out_overflow_o = out_ovf_q;

endmodule
